// ----- src/assert_macros.svh -----
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tfi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tfi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  // exact products and sums of three products
  localparam int WIDE_BITS  = 2 * COORD_BITS + 2;
  localparam int ROOT_W     = WIDE_BITS + 1;
  // dividend bits of a fixed-point division
  localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef struct packed {
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
  } in_t;

  typedef struct packed {
    logic [1:0] row_number;
    coord_t     inverse_col0;
    coord_t     inverse_col1;
    coord_t     inverse_col2;
    coord_t     offset_component;
    logic [1:0] status;
    logic       last_row;
  } out_t;

  typedef struct packed {
    coord_t value;
    logic   sat;
  } fin_t;

  typedef struct packed {
    logic [WIDE_BITS-1:0] x;
    logic [ROOT_W-1:0]    res;
  } root_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] rem;
    logic [QUO_BITS-1:0]   nq;
  } div_t;

  function automatic logic [COORD_BITS-1:0] mag32(coord_t v);
    logic [COORD_BITS-1:0] u;
    u = v;
    return v[COORD_BITS-1] ? (~u + 1'b1) : u;
  endfunction

  // clamp a sign and magnitude into the coordinate range
  function automatic fin_t clamp_mag(logic neg, logic [WIDE_BITS-1:0] mag);
    localparam logic [WIDE_BITS-1:0] LIM = WIDE_BITS'(1) << (COORD_BITS - 1);
    fin_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > LIM) begin
        r.sat   = 1'b1;
        r.value = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        r.value = ~mag[COORD_BITS-1:0] + 1'b1;
      end
    end else begin
      if (mag > LIM - 1'b1) begin
        r.sat   = 1'b1;
        r.value = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
        r.value = mag[COORD_BITS-1:0];
      end
    end
    return r;
  endfunction

  // divide by 2^FRAC_BITS, round half away from zero, saturate
  function automatic fin_t round_sat(wide_t v);
    localparam logic [WIDE_BITS-1:0] HALF = WIDE_BITS'(1) << (FRAC_BITS - 1);
    logic                 neg;
    logic [WIDE_BITS-1:0] vu;
    logic [WIDE_BITS-1:0] mag;
    neg = v[WIDE_BITS-1];
    vu  = v;
    mag = neg ? (~vu + 1'b1) : vu;
    mag = (mag + HALF) >> FRAC_BITS;
    return clamp_mag(neg, mag);
  endfunction

  // b - a, saturated
  function automatic fin_t edge_sat(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        du;
    logic                       neg;
    d   = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
    du  = d;
    neg = d[COORD_BITS];
    du  = neg ? (~du + 1'b1) : du;
    return clamp_mag(neg, WIDE_BITS'(du));
  endfunction

  function automatic wide_t smul(coord_t a, coord_t b);
    logic signed [2*COORD_BITS-1:0] p;
    p = a * b;
    return wide_t'(p);
  endfunction

  // one result bit of a digit-by-digit square root, trial bit 4^k
  function automatic root_t root_step(root_t r, int k);
    logic [ROOT_W-1:0] b;
    logic [ROOT_W-1:0] t;
    root_t             q;
    b = ROOT_W'(1) << (2 * k);
    t = r.res + b;
    q = r;
    if ({1'b0, r.x} >= t) begin
      q.x   = r.x - t[WIDE_BITS-1:0];
      q.res = (r.res >> 1) + b;
    end else begin
      q.res = r.res >> 1;
    end
    return q;
  endfunction

  function automatic div_t div_load(coord_t num);
    div_t d;
    d.rem = '0;
    d.nq  = QUO_BITS'(mag32(num)) << FRAC_BITS;
    return d;
  endfunction

  // one quotient bit of a restoring division
  function automatic div_t div_step(div_t d, logic [COORD_BITS-1:0] ud);
    logic [COORD_BITS:0] r2;
    logic                qb;
    div_t                q;
    r2 = {d.rem, d.nq[QUO_BITS-1]};
    qb = (r2 >= {1'b0, ud});
    if (qb) r2 = r2 - {1'b0, ud};
    q.rem = r2[COORD_BITS-1:0];
    q.nq  = {d.nq[QUO_BITS-2:0], qb};
    return q;
  endfunction

  function automatic fin_t div_finish(logic neg, div_t d, logic [COORD_BITS-1:0] ud);
    logic [QUO_BITS:0] q;
    logic              up;
    up = ({d.rem, 1'b0} >= {1'b0, ud});
    q  = {1'b0, d.nq} + (QUO_BITS+1)'(up);
    return clamp_mag(neg, WIDE_BITS'(q));
  endfunction

endpackage

`default_nettype wire

// ----- src/triangle_frame_inverse_core.sv -----
// triangle frame inverse core
// input channel: one triangle (three corners, signed Q16.16) per item on
// in_valid / in_stall / in_data. result channel: three items per triangle on
// out_valid / out_stall / out_data, rows 0, 1, 2 in order, last_row on row 2.
// each result carries one row of the inverse of the matrix with rows
// edge1, edge2 and the fourth-vertex offset, plus that row's offset component.
// row 0 appears once the triangle has passed the last pipeline stage into the
// row serializer; rows 1 and 2 follow on the next cycles when the receiver
// does not stall. the serializer takes a new triangle when idle or as row 2
// goes out; the 168-stage pipeline takes a triangle every cycle unless its
// last stage waits (two 48-stage radix-2 dividers and two square roots set its depth).
// reset clears every valid bit and the serializer; no result is pending after.
// when out_stall is high the current row holds, the pipeline freezes once its
// last stage is full, and in_stall rises; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_frame_inverse_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire tfi_pkg::in_t  in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      tfi_pkg::out_t out_data
);

  localparam int W         = tfi_pkg::COORD_BITS;
  localparam int RT1_STEPS = tfi_pkg::WIDE_BITS / 2;
  localparam int RT2_STEPS = (RT1_STEPS + tfi_pkg::FRAC_BITS + 1) / 2;
  localparam int QB        = tfi_pkg::QUO_BITS;

  localparam int P_NPROD = 1;
  localparam int P_NDIFF = 2;
  localparam int P_NFIN  = 3;
  localparam int P_SQ    = 4;
  localparam int P_SUM   = 5;
  localparam int P_RT1   = 6;
  localparam int P_RT2   = P_RT1 + RT1_STEPS;
  localparam int P_DV1   = P_RT2 + RT2_STEPS;
  localparam int P_OFIN  = P_DV1 + QB;
  localparam int P_KPROD = P_OFIN + 1;
  localparam int P_KDIFF = P_KPROD + 1;
  localparam int P_KFIN  = P_KDIFF + 1;
  localparam int P_DPROD = P_KFIN + 1;
  localparam int P_DSUM  = P_DPROD + 1;
  localparam int P_DFIN  = P_DSUM + 1;
  localparam int P_DV2   = P_DFIN + 1;
  localparam int P_IFIN  = P_DV2 + QB;
  localparam int DEPTH   = P_IFIN + 1;

  localparam logic [1:0] ROW_LAST = 2'd2;

  typedef struct packed {
    tfi_pkg::coord_t [2:0]            e1;
    tfi_pkg::coord_t [2:0]            e2;
    tfi_pkg::coord_t [2:0]            n;
    tfi_pkg::coord_t [2:0]            o;
    tfi_pkg::coord_t [2:0]            k0;
    tfi_pkg::coord_t [2:0]            k1;
    tfi_pkg::coord_t                  det;
    logic [W-1:0]                     den;
    tfi_pkg::coord_t [2:0][2:0]       inv;
    tfi_pkg::wide_t [11:0]            w;
    tfi_pkg::root_t                   rt;
    tfi_pkg::div_t [2:0][2:0]         dv;
    logic [2:0][2:0]                  neg;
    logic                             sat;
    logic                             degen;
  } st_t;

  typedef struct packed {
    tfi_pkg::coord_t [2:0][2:0] inv;
    tfi_pkg::coord_t [2:0]      o;
    logic [1:0]                 status;
  } res_t;

  function automatic st_t edge_fn(tfi_pkg::in_t d);
    st_t                  q;
    tfi_pkg::fin_t        f;
    tfi_pkg::coord_t [2:0] a;
    tfi_pkg::coord_t [2:0] b;
    tfi_pkg::coord_t [2:0] c;
    q = '0;
    a = {d.corner_a_z, d.corner_a_y, d.corner_a_x};
    b = {d.corner_b_z, d.corner_b_y, d.corner_b_x};
    c = {d.corner_c_z, d.corner_c_y, d.corner_c_x};
    for (int i = 0; i < 3; i++) begin
      f = tfi_pkg::edge_sat(a[i], b[i]);
      q.e1[i] = f.value;
      q.sat = q.sat | f.sat;
      f = tfi_pkg::edge_sat(a[i], c[i]);
      q.e2[i] = f.value;
      q.sat = q.sat | f.sat;
    end
    return q;
  endfunction

  function automatic st_t step_fn(int s, st_t p);
    st_t           q;
    tfi_pkg::fin_t f;
    int            j;
    q = p;
    if (s == P_NPROD) begin
      q.w[0] = tfi_pkg::smul(p.e1[1], p.e2[2]);
      q.w[1] = tfi_pkg::smul(p.e1[2], p.e2[1]);
      q.w[2] = tfi_pkg::smul(p.e1[2], p.e2[0]);
      q.w[3] = tfi_pkg::smul(p.e1[0], p.e2[2]);
      q.w[4] = tfi_pkg::smul(p.e1[0], p.e2[1]);
      q.w[5] = tfi_pkg::smul(p.e1[1], p.e2[0]);
    end else if (s == P_NDIFF || s == P_KDIFF) begin
      for (int i = 0; i < 6; i++) q.w[i] = p.w[2*i] - p.w[2*i+1];
    end else if (s == P_NFIN) begin
      for (int i = 0; i < 3; i++) begin
        f = tfi_pkg::round_sat(p.w[i]);
        q.n[i] = f.value;
        q.sat = q.sat | f.sat;
      end
      q.degen = (q.n[0] == '0) && (q.n[1] == '0) && (q.n[2] == '0);
    end else if (s == P_SQ) begin
      for (int i = 0; i < 3; i++) q.w[i] = tfi_pkg::smul(p.n[i], p.n[i]);
    end else if (s == P_SUM || s == P_DSUM) begin
      q.w[0] = p.w[0] + p.w[1] + p.w[2];
    end else if (s >= P_RT1 && s < P_RT2) begin
      j = s - P_RT1;
      if (j == 0) begin
        q.rt.x   = p.w[0];
        q.rt.res = '0;
      end
      q.rt = tfi_pkg::root_step(q.rt, RT1_STEPS - 1 - j);
    end else if (s >= P_RT2 && s < P_DV1) begin
      j = s - P_RT2;
      if (j == 0) begin
        // length in fixed point: sqrt of len * 2^frac
        q.rt.x   = tfi_pkg::WIDE_BITS'(p.rt.res[RT1_STEPS-1:0]) << tfi_pkg::FRAC_BITS;
        q.rt.res = '0;
      end
      q.rt = tfi_pkg::root_step(q.rt, RT2_STEPS - 1 - j);
    end else if (s >= P_DV1 && s < P_OFIN) begin
      j = s - P_DV1;
      if (j == 0) begin
        q.degen = p.degen | (p.rt.res == '0);
        q.den   = W'(p.rt.res[RT2_STEPS-1:0]);
        for (int i = 0; i < 3; i++) begin
          q.neg[0][i] = p.n[i][W-1];
          q.dv[0][i]  = tfi_pkg::div_load(p.n[i]);
        end
      end
      for (int i = 0; i < 3; i++) q.dv[0][i] = tfi_pkg::div_step(q.dv[0][i], q.den);
    end else if (s == P_OFIN) begin
      for (int i = 0; i < 3; i++) begin
        f = tfi_pkg::div_finish(p.neg[0][i], p.dv[0][i], p.den);
        q.o[i] = f.value;
        q.sat = q.sat | f.sat;
      end
    end else if (s == P_KPROD) begin
      // k0 = e2 x o, k1 = o x e1
      q.w[0]  = tfi_pkg::smul(p.e2[1], p.o[2]);
      q.w[1]  = tfi_pkg::smul(p.e2[2], p.o[1]);
      q.w[2]  = tfi_pkg::smul(p.e2[2], p.o[0]);
      q.w[3]  = tfi_pkg::smul(p.e2[0], p.o[2]);
      q.w[4]  = tfi_pkg::smul(p.e2[0], p.o[1]);
      q.w[5]  = tfi_pkg::smul(p.e2[1], p.o[0]);
      q.w[6]  = tfi_pkg::smul(p.o[1], p.e1[2]);
      q.w[7]  = tfi_pkg::smul(p.o[2], p.e1[1]);
      q.w[8]  = tfi_pkg::smul(p.o[2], p.e1[0]);
      q.w[9]  = tfi_pkg::smul(p.o[0], p.e1[2]);
      q.w[10] = tfi_pkg::smul(p.o[0], p.e1[1]);
      q.w[11] = tfi_pkg::smul(p.o[1], p.e1[0]);
    end else if (s == P_KFIN) begin
      for (int i = 0; i < 3; i++) begin
        f = tfi_pkg::round_sat(p.w[i]);
        q.k0[i] = f.value;
        q.sat = q.sat | f.sat;
        f = tfi_pkg::round_sat(p.w[3+i]);
        q.k1[i] = f.value;
        q.sat = q.sat | f.sat;
      end
    end else if (s == P_DPROD) begin
      for (int i = 0; i < 3; i++) q.w[i] = tfi_pkg::smul(p.e1[i], p.k0[i]);
    end else if (s == P_DFIN) begin
      f = tfi_pkg::round_sat(p.w[0]);
      q.det   = f.value;
      q.sat   = p.sat | f.sat;
      q.degen = p.degen | (f.value == '0);
    end else if (s >= P_DV2 && s < P_IFIN) begin
      j = s - P_DV2;
      if (j == 0) begin
        q.den = tfi_pkg::mag32(p.det);
        for (int i = 0; i < 3; i++) begin
          q.neg[i][0] = p.k0[i][W-1] ^ p.det[W-1];
          q.neg[i][1] = p.k1[i][W-1] ^ p.det[W-1];
          q.neg[i][2] = p.n[i][W-1] ^ p.det[W-1];
          q.dv[i][0]  = tfi_pkg::div_load(p.k0[i]);
          q.dv[i][1]  = tfi_pkg::div_load(p.k1[i]);
          q.dv[i][2]  = tfi_pkg::div_load(p.n[i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) q.dv[i][c] = tfi_pkg::div_step(q.dv[i][c], q.den);
      end
    end else if (s == P_IFIN) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          f = tfi_pkg::div_finish(p.neg[i][c], p.dv[i][c], p.den);
          q.inv[i][c] = f.value;
          q.sat = q.sat | f.sat;
        end
      end
      if (p.degen) begin
        q.inv = '0;
        q.o   = '0;
      end
    end
    return q;
  endfunction

  logic [DEPTH-1:0] vld_r;
  st_t              st_r [DEPTH];
  res_t             ser_r;
  logic             busy_r;
  logic [1:0]       row_r;
  logic             out_accept;
  logic             ser_take;
  logic             adv;

  assign out_accept = busy_r && !out_stall;
  assign ser_take   = !busy_r || (out_accept && row_r == ROW_LAST);
  assign adv        = !vld_r[DEPTH-1] || ser_take;
  assign in_stall   = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= edge_fn(in_data);
      for (int s = 1; s < DEPTH; s++) st_r[s] <= step_fn(s, st_r[s-1]);
    end
  end

  // row serializer: three items per triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else if (adv && vld_r[DEPTH-1]) begin
      busy_r <= 1'b1;
      row_r  <= '0;
    end else if (out_accept) begin
      if (row_r == ROW_LAST) begin
        busy_r <= 1'b0;
      end else begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[DEPTH-1]) begin
      ser_r.inv    <= st_r[DEPTH-1].inv;
      ser_r.o      <= st_r[DEPTH-1].o;
      ser_r.status <= st_r[DEPTH-1].degen ? tfi_pkg::STATUS_DEGEN :
                      st_r[DEPTH-1].sat   ? tfi_pkg::STATUS_SAT   : tfi_pkg::STATUS_OK;
    end
  end

  assign out_valid                 = busy_r;
  assign out_data.row_number       = row_r;
  assign out_data.inverse_col0     = ser_r.inv[row_r][0];
  assign out_data.inverse_col1     = ser_r.inv[row_r][1];
  assign out_data.inverse_col2     = ser_r.inv[row_r][2];
  assign out_data.offset_component = ser_r.o[row_r];
  assign out_data.status           = ser_r.status;
  assign out_data.last_row         = (row_r == ROW_LAST);

  `ASSERT_NEXT(a_row_order, out_accept && row_r != ROW_LAST, out_valid && row_r == $past(row_r) + 2'd1, "row sequence broken")
  `ASSERT_IMPLY(a_degen_zero, out_valid && out_data.status == tfi_pkg::STATUS_DEGEN, out_data.inverse_col0 == '0 && out_data.inverse_col1 == '0 && out_data.inverse_col2 == '0 && out_data.offset_component == '0, "degenerate result not zero")
  `ASSERT_NEXT(a_hold_last, vld_r[DEPTH-1] && !adv, vld_r[DEPTH-1] && busy_r, "last stage item lost")

endmodule

`default_nettype wire
